@@ src/assert_macros.svh @@
// assertion macros used by the top level of the frame allocator
// no dependencies; define ASSERT_OFF to drop every check
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// clocked property with reset disable
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// expression that must never be true at a clock edge
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

@@ src/cfa_pkg.sv @@
// constants and codes of the contiguous frame allocator
// no dependencies; imported by the top level
`default_nettype none

package cfa_pkg;

    localparam int MAX_FRAMES      = 16384;
    localparam int FRAME_NUM_BITS  = 20;
    localparam int FRAMES_PER_WORD = 4;
    localparam int STATE_BITS      = 2;
    localparam int WORD_W          = FRAMES_PER_WORD * STATE_BITS;
    localparam int WORDS           = MAX_FRAMES / FRAMES_PER_WORD;
    localparam int WADDR_W         = $clog2(WORDS);
    localparam int SLOT_W          = $clog2(FRAMES_PER_WORD);
    localparam int IDX_W           = $clog2(MAX_FRAMES);
    localparam int COUNT_W         = 15;
    localparam int TALLY_W         = $clog2(FRAMES_PER_WORD + 1);
    localparam int FUNC_W          = 2;
    localparam int STAT_W          = 2;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = FRAME_NUM_BITS;
    localparam int IN_TDATA_W      = ((FRAME_NUM_BITS + COUNT_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W     = ((FRAME_NUM_BITS + COUNT_W + 7) / 8) * 8;

    // frame states
    localparam logic [STATE_BITS-1:0] FS_FREE = 2'd0;
    localparam logic [STATE_BITS-1:0] FS_USED = 2'd1;
    localparam logic [STATE_BITS-1:0] FS_HEAD = 2'd2;

    // request codes
    localparam logic [FUNC_W-1:0] FN_ALLOC   = 2'd0;
    localparam logic [FUNC_W-1:0] FN_RELEASE = 2'd1;
    localparam logic [FUNC_W-1:0] FN_RESERVE = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOFIT   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOTHEAD = 2'd2;
    localparam logic [STAT_W-1:0] STAT_OUT     = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INFO      = 2'd2;

endpackage

`default_nettype wire

@@ src/cfa_ram.sv @@
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module cfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ src/contiguous_frame_allocator.sv @@
// top level of the contiguous frame allocator: sequencer around the frame bitmap
// depends on cfa_pkg, cfa_ram and assert_macros.svh
// a request goes through decode, a walk over the bitmap words and a load of the result
// allocate walks up to 4096 words (4 frames each) in the first-fit scan, then marks the run
// release and reserve walk the words they touch; next request only once back in idle
// reset and defined config writes run a clearing pass, no request taken meanwhile
`default_nettype none
`include "assert_macros.svh"

module contiguous_frame_allocator
    import cfa_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // request channel
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // req_frame [19:0], frame_count [34:20], zero pad above
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // func [1:0]
    input  wire logic [FUNC_W-1:0]      s_axis_tuser,
    // result channel
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // head_frame [19:0], free_frames [34:20], zero pad above
    output logic      [OUT_TDATA_W-1:0] m_axis_tdata,
    // status [1:0]
    output logic      [STAT_W-1:0]      m_axis_tuser,
    // configuration write channel
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int END_W = COUNT_W + 1;
    localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(WORDS - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_MARK,
        S_FREE,
        S_DONE
    } st_t;

    // control state
    st_t                       state_reg, state_next;
    logic [WADDR_W-1:0]        word_reg, word_next;
    logic [FRAME_NUM_BITS-1:0] base_reg, base_next;
    logic [COUNT_W-1:0]        size_reg, size_next;   // effective pool size
    logic                      info_reg, info_next;
    logic [COUNT_W-1:0]        free_reg, free_next;
    logic                      out_valid_reg, out_valid_next;

    // request payload and walk context
    logic [FUNC_W-1:0]         func_reg, func_next;
    logic [FRAME_NUM_BITS-1:0] frame_reg, frame_next;
    logic [COUNT_W-1:0]        count_reg, count_next;
    logic [IDX_W-1:0]          start_reg, start_next;
    logic [COUNT_W-1:0]        end_reg, end_next;
    logic [COUNT_W-1:0]        run_reg, run_next;
    logic                      act_reg, act_next;
    logic                      first_reg, first_next;
    logic                      alloc_reg, alloc_next;
    logic [STAT_W-1:0]         status_reg, status_next;
    logic [FRAME_NUM_BITS-1:0] head_reg, head_next;
    logic [FRAME_NUM_BITS-1:0] out_head_reg, out_head_next;
    logic [STAT_W-1:0]         out_status_reg, out_status_next;
    logic [COUNT_W-1:0]        out_free_reg, out_free_next;

    // bitmap port
    logic                      ram_we;
    logic [WADDR_W-1:0]        ram_waddr;
    logic [WADDR_W-1:0]        ram_raddr;
    logic [WORD_W-1:0]         ram_wdata;
    logic [WORD_W-1:0]         ram_rdata;

    cfa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS)
    ) u_bitmap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // the word read this cycle is always the one at word_reg
    assign ram_waddr = word_reg;
    assign ram_raddr = word_next;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'({out_free_reg, out_head_reg});
    assign m_axis_tuser  = out_status_reg;

    always_comb
    begin
        logic [COUNT_W-1:0]        fidx;
        logic [COUNT_W-1:0]        start_ext;
        logic [COUNT_W-1:0]        run_v;
        logic                      found_v;
        logic [COUNT_W-1:0]        hit_v;
        logic [COUNT_W-1:0]        hv;
        logic                      act_v;
        logic                      head_ok_v;
        logic [TALLY_W-1:0]        cnt_v;
        logic [STATE_BITS-1:0]     old_v;
        logic [WORD_W-1:0]         wr_word;
        logic [COUNT_W-1:0]        next_first;
        logic [END_W-1:0]          res_end;
        logic [FRAME_NUM_BITS-1:0] idx_v;
        logic                      in_pool;
        logic [COUNT_W-1:0]        cfg_size_v;
        logic                      cfg_info_v;
        logic                      cfg_hit;

        state_next      = state_reg;
        word_next       = word_reg;
        base_next       = base_reg;
        size_next       = size_reg;
        info_next       = info_reg;
        free_next       = free_reg;
        out_valid_next  = out_valid_reg;
        func_next       = func_reg;
        frame_next      = frame_reg;
        count_next      = count_reg;
        start_next      = start_reg;
        end_next        = end_reg;
        run_next        = run_reg;
        act_next        = act_reg;
        first_next      = first_reg;
        alloc_next      = alloc_reg;
        status_next     = status_reg;
        head_next       = head_reg;
        out_head_next   = out_head_reg;
        out_status_next = out_status_reg;
        out_free_next   = out_free_reg;
        ram_we          = 1'b0;
        ram_wdata       = ram_rdata;

        // per-word update of the four frame slots
        start_ext  = COUNT_W'(start_reg);
        next_first = COUNT_W'({word_reg, SLOT_W'(0)}) + COUNT_W'(FRAMES_PER_WORD);
        run_v      = run_reg;
        found_v    = 1'b0;
        hit_v      = '0;
        act_v      = first_reg ? 1'b0 : act_reg;
        head_ok_v  = 1'b0;
        cnt_v      = '0;
        wr_word    = ram_rdata;
        for (int j = 0; j < FRAMES_PER_WORD; j++)
        begin
            fidx  = COUNT_W'({word_reg, SLOT_W'(j)});
            old_v = ram_rdata[j*STATE_BITS +: STATE_BITS];
            unique case (state_reg)
                S_SCAN:
                begin
                    // running length of free frames, frames past the pool end break it
                    if (!found_v)
                    begin
                        if ((fidx < size_reg) && (old_v == FS_FREE))
                        begin
                            run_v = run_v + COUNT_W'(1);
                        end
                        else
                        begin
                            run_v = '0;
                        end
                        if (run_v == count_reg)
                        begin
                            found_v = 1'b1;
                            hit_v   = fidx;
                        end
                    end
                end
                S_MARK:
                begin
                    if ((fidx >= start_ext) && (fidx < end_reg))
                    begin
                        if (old_v == FS_FREE)
                        begin
                            cnt_v = cnt_v + TALLY_W'(1);
                        end
                        wr_word[j*STATE_BITS +: STATE_BITS] =
                            (fidx == start_ext) ? FS_HEAD : FS_USED;
                    end
                end
                S_FREE:
                begin
                    if (first_reg && (fidx == start_ext))
                    begin
                        head_ok_v = (old_v == FS_HEAD);
                        act_v     = head_ok_v;
                        if (head_ok_v)
                        begin
                            wr_word[j*STATE_BITS +: STATE_BITS] = FS_FREE;
                            cnt_v = cnt_v + TALLY_W'(1);
                        end
                    end
                    else if (act_v && (fidx < size_reg) && (old_v == FS_USED))
                    begin
                        wr_word[j*STATE_BITS +: STATE_BITS] = FS_FREE;
                        cnt_v = cnt_v + TALLY_W'(1);
                    end
                    else
                    begin
                        act_v = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end

        hv      = hit_v + COUNT_W'(1) - count_reg;
        idx_v   = frame_reg - base_reg;
        in_pool = (idx_v < FRAME_NUM_BITS'(size_reg));
        res_end = END_W'(idx_v[IDX_W-1:0])
                + END_W'((count_reg == '0) ? COUNT_W'(1) : count_reg);

        if (m_axis_tvalid && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                // wipe one word a cycle; the info frame is a one-frame run
                ram_we    = 1'b1;
                ram_wdata = ((word_reg == '0) && info_reg) ? WORD_W'(FS_HEAD) : '0;
                if (word_reg == LAST_WORD)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    word_next = word_reg + WADDR_W'(1);
                end
            end
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    func_next  = s_axis_tuser;
                    frame_next = s_axis_tdata[FRAME_NUM_BITS-1:0];
                    count_next = s_axis_tdata[FRAME_NUM_BITS +: COUNT_W];
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                status_next = STAT_OK;
                head_next   = '0;
                first_next  = 1'b1;
                act_next    = 1'b0;
                run_next    = '0;
                alloc_next  = 1'b0;
                unique case (func_reg)
                    FN_ALLOC:
                    begin
                        if ((count_reg == '0) || (count_reg > size_reg))
                        begin
                            status_next = STAT_NOFIT;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            word_next  = '0;
                            state_next = S_SCAN;
                        end
                    end
                    FN_RELEASE:
                    begin
                        if (!in_pool)
                        begin
                            status_next = STAT_OUT;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            start_next = idx_v[IDX_W-1:0];
                            word_next  = idx_v[IDX_W-1:SLOT_W];
                            state_next = S_FREE;
                        end
                    end
                    FN_RESERVE:
                    begin
                        if (!in_pool)
                        begin
                            status_next = STAT_OUT;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            // range clipped at the pool end
                            start_next = idx_v[IDX_W-1:0];
                            end_next   = (res_end > END_W'(size_reg)) ?
                                         size_reg : res_end[COUNT_W-1:0];
                            word_next  = idx_v[IDX_W-1:SLOT_W];
                            state_next = S_MARK;
                        end
                    end
                    default:
                    begin
                        status_next = STAT_OUT;
                        state_next  = S_DONE;
                    end
                endcase
            end
            S_SCAN:
            begin
                run_next = run_v;
                if (found_v)
                begin
                    start_next = hv[IDX_W-1:0];
                    end_next   = hit_v + COUNT_W'(1);
                    alloc_next = 1'b1;
                    word_next  = hv[IDX_W-1:SLOT_W];
                    state_next = S_MARK;
                end
                else if ((word_reg == LAST_WORD) || (next_first >= size_reg))
                begin
                    status_next = STAT_NOFIT;
                    state_next  = S_DONE;
                end
                else
                begin
                    word_next = word_reg + WADDR_W'(1);
                end
            end
            S_MARK:
            begin
                ram_we    = 1'b1;
                ram_wdata = wr_word;
                free_next = free_reg - COUNT_W'(cnt_v);
                if ((word_reg != LAST_WORD) && (next_first < end_reg))
                begin
                    word_next = word_reg + WADDR_W'(1);
                end
                else
                begin
                    head_next  = alloc_reg ? (base_reg + FRAME_NUM_BITS'(start_reg)) : '0;
                    state_next = S_DONE;
                end
            end
            S_FREE:
            begin
                ram_we     = 1'b1;
                ram_wdata  = wr_word;
                free_next  = free_reg + COUNT_W'(cnt_v);
                first_next = 1'b0;
                act_next   = act_v;
                if (first_reg && !head_ok_v)
                begin
                    status_next = STAT_NOTHEAD;
                end
                if (act_v && (word_reg != LAST_WORD))
                begin
                    word_next = word_reg + WADDR_W'(1);
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // result register frees up on the transfer of the previous result
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_head_next   = head_reg;
                    out_status_next = status_reg;
                    out_free_next   = free_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase

        // any write to a defined register re-initializes the pool
        cfg_size_v = size_reg;
        cfg_info_v = info_reg;
        cfg_hit    = 1'b0;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_POOL_BASE:
                begin
                    base_next = cfg_data;
                    cfg_hit   = 1'b1;
                end
                CFG_POOL_SIZE:
                begin
                    if (cfg_data[COUNT_W-1:0] == '0)
                    begin
                        cfg_size_v = COUNT_W'(1);
                    end
                    else if (cfg_data[COUNT_W-1:0] > COUNT_W'(MAX_FRAMES))
                    begin
                        cfg_size_v = COUNT_W'(MAX_FRAMES);
                    end
                    else
                    begin
                        cfg_size_v = cfg_data[COUNT_W-1:0];
                    end
                    cfg_hit = 1'b1;
                end
                CFG_INFO:
                begin
                    cfg_info_v = cfg_data[0];
                    cfg_hit    = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        if (cfg_hit)
        begin
            size_next  = cfg_size_v;
            info_next  = cfg_info_v;
            free_next  = cfg_size_v - COUNT_W'(cfg_info_v);
            word_next  = '0;
            state_next = S_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            word_reg      <= '0;
            base_reg      <= '0;
            size_reg      <= COUNT_W'(MAX_FRAMES);
            info_reg      <= 1'b1;
            free_reg      <= COUNT_W'(MAX_FRAMES - 1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            word_reg      <= word_next;
            base_reg      <= base_next;
            size_reg      <= size_next;
            info_reg      <= info_next;
            free_reg      <= free_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload and walk context, no reset needed
    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        frame_reg      <= frame_next;
        count_reg      <= count_next;
        start_reg      <= start_next;
        end_reg        <= end_next;
        run_reg        <= run_next;
        act_reg        <= act_next;
        first_reg      <= first_next;
        alloc_reg      <= alloc_next;
        status_reg     <= status_next;
        head_reg       <= head_next;
        out_head_reg   <= out_head_next;
        out_status_reg <= out_status_next;
        out_free_reg   <= out_free_next;
    end

    // checks
    `ASSERT_NEVER(a_free_bound, clk, rst_n, free_reg > size_reg, "free count above pool size")
    `ASSERT_CLK(a_rmw_sep, clk, rst_n, (ram_we && (state_reg == S_MARK || state_reg == S_FREE) && (state_next == state_reg)) |-> (ram_raddr != ram_waddr), "read and write hit the same word")
    `ASSERT_CLK(a_scan_hold, clk, rst_n, (state_reg == S_SCAN && !cfg_valid) |=> $stable(free_reg), "free count moved during scan")
    `ASSERT_CLK(a_result_src, clk, rst_n, $rose(m_axis_tvalid) |-> $past(state_reg == S_DONE), "result raised outside done")

endmodule

`default_nettype wire

@@ bench/tb_contiguous_frame_allocator.sv @@
`timescale 1ns / 100ps
// self-checking bench for the contiguous frame allocator: directed and random requests
// over several pool settings, each result checked against a bitmap predictor
// depends on cfa_pkg and the contiguous_frame_allocator rtl

module tb_contiguous_frame_allocator;
    import cfa_pkg::*;

    // request code the block does not define, answered with out of pool
    localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
    // cycles allowed after the last result before touching config or ending
    localparam int SETTLE_CYCLES = 16;

    typedef struct packed {
        logic [FRAME_NUM_BITS-1:0] head;
        logic [STAT_W-1:0]         status;
        logic [COUNT_W-1:0]        free;
    } alloc_result_t;

    // bitmap predictor plus queue of pending results
    class frame_pool_scoreboard;
        logic [STATE_BITS-1:0]     frame_state [MAX_FRAMES];
        logic [FRAME_NUM_BITS-1:0] base;
        logic [COUNT_W-1:0]        size_reg;
        logic                      info;
        int                        free_left;
        alloc_result_t             pending_q [$];
        int                        errors;
        int                        requests;
        int                        checked;

        function new();
            base     = '0;
            size_reg = 15'd16384;
            info     = 1'b1;
            errors   = 0;
            requests = 0;
            checked  = 0;
            reinit();
        endfunction

        // size register saturated into 1..MAX_FRAMES
        function int live_size();
            int sz;
            sz = int'(size_reg);
            if (sz < 1)
                sz = 1;
            if (sz > MAX_FRAMES)
                sz = MAX_FRAMES;
            return sz;
        endfunction

        function void reinit();
            int sz;
            sz = live_size();
            foreach (frame_state[i])
                frame_state[i] = FS_FREE;
            free_left = sz;
            if (info)
            begin
                frame_state[0] = FS_HEAD;
                free_left      = sz - 1;
            end
        endfunction

        // any write to a defined register clears the pool again
        function void configure(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_POOL_BASE: base     = data[FRAME_NUM_BITS-1:0];
                CFG_POOL_SIZE: size_reg = data[COUNT_W-1:0];
                CFG_INFO:      info     = data[0];
                default:       return;
            endcase
            reinit();
        endfunction

        function int pending();
            return pending_q.size();
        endfunction

        // first head at or after a pool index, wrapping; -1 when none
        function int find_head(int from);
            int sz;
            int j;
            sz = live_size();
            for (int k = 0; k < sz; k++)
            begin
                j = (from + k) % sz;
                if (frame_state[j] == FS_HEAD)
                    return j;
            end
            return -1;
        endfunction

        // apply one accepted request to the bitmap and queue its result
        function void note_request(logic [FUNC_W-1:0] func, logic [FRAME_NUM_BITS-1:0] frame,
                                   logic [COUNT_W-1:0] count);
            logic [FRAME_NUM_BITS-1:0] idx20;
            alloc_result_t             res;
            int                        sz;
            int                        idx;
            int                        run;
            int                        h;
            int                        last;
            int                        i;
            sz         = live_size();
            idx20      = frame - base;
            idx        = int'(idx20);
            res.head   = '0;
            res.status = STAT_OK;
            requests++;
            case (func)
                FN_ALLOC:
                begin
                    res.status = STAT_NOFIT;
                    if (count >= 1 && int'(count) <= sz)
                    begin
                        run = 0;
                        for (i = 0; i < sz; i++)
                        begin
                            run = (frame_state[i] == FS_FREE) ? run + 1 : 0;
                            if (run == int'(count))
                            begin
                                h = i + 1 - run;
                                frame_state[h] = FS_HEAD;
                                for (int k = h + 1; k <= i; k++)
                                    frame_state[k] = FS_USED;
                                free_left -= run;
                                res.head   = base + h[FRAME_NUM_BITS-1:0];
                                res.status = STAT_OK;
                                break;
                            end
                        end
                    end
                end
                FN_RELEASE:
                begin
                    if (idx >= sz)
                        res.status = STAT_OUT;
                    else if (frame_state[idx] != FS_HEAD)
                        res.status = STAT_NOTHEAD;
                    else
                    begin
                        // head plus the used tail that follows it
                        frame_state[idx] = FS_FREE;
                        free_left++;
                        for (i = idx + 1; i < sz && frame_state[i] == FS_USED; i++)
                        begin
                            frame_state[i] = FS_FREE;
                            free_left++;
                        end
                    end
                end
                FN_RESERVE:
                begin
                    if (idx >= sz)
                        res.status = STAT_OUT;
                    else
                    begin
                        // zero count still marks one head; range clipped at pool end
                        last = idx + ((count != 0) ? int'(count) : 1);
                        if (last > sz)
                            last = sz;
                        for (i = idx; i < last; i++)
                        begin
                            if (frame_state[i] == FS_FREE)
                                free_left--;
                            frame_state[i] = (i == idx) ? FS_HEAD : FS_USED;
                        end
                    end
                end
                default:
                    res.status = STAT_OUT;
            endcase
            res.free = free_left[COUNT_W-1:0];
            pending_q.push_back(res);
        endfunction

        function void check_result(logic [FRAME_NUM_BITS-1:0] head, logic [STAT_W-1:0] status,
                                   logic [COUNT_W-1:0] free);
            alloc_result_t exp_res;
            checked++;
            if (pending_q.size() == 0)
            begin
                $error("result with nothing pending: head_frame %0h status %0d free_frames %0d",
                       head, status, free);
                errors++;
                return;
            end
            exp_res = pending_q.pop_front();
            if (head !== exp_res.head)
            begin
                $error("head_frame: expected %0h, actual %0h", exp_res.head, head);
                errors++;
            end
            if (status !== exp_res.status)
            begin
                $error("status: expected %0d, actual %0d", exp_res.status, status);
                errors++;
            end
            if (free !== exp_res.free)
            begin
                $error("free_frames: expected %0d, actual %0d", exp_res.free, free);
                errors++;
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [FUNC_W-1:0]      s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [STAT_W-1:0]      m_axis_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // set for a stretch of the run with no gaps on either side
    bit                     steady_flow = 1'b0;
    int                     settings = 1;
    frame_pool_scoreboard   sb;

    contiguous_frame_allocator u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // result side stalls about 23 percent of the time
    always @(posedge clk)
        m_axis_tready <= steady_flow || ($urandom_range(0, 99) >= 23);

    // every result transfer goes to the scoreboard
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata[FRAME_NUM_BITS-1:0], m_axis_tuser,
                            m_axis_tdata[FRAME_NUM_BITS +: COUNT_W]);
    end

    // one request transfer; valid is left high so the caller decides what follows
    task automatic send_req(logic [FUNC_W-1:0] func, logic [FRAME_NUM_BITS-1:0] frame,
                            logic [COUNT_W-1:0] count);
        while (!steady_flow && $urandom_range(0, 99) < 23)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= {{(IN_TDATA_W - FRAME_NUM_BITS - COUNT_W){1'b0}}, count, frame};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_request(func, frame, count);
    endtask

    task automatic stop_req();
        s_axis_tvalid <= 1'b0;
    endtask

    // all results back, then a quiet spell for the block to settle
    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.configure(idx, data);
    endtask

    // new pool setting, only while nothing is in flight
    task automatic set_pool(logic [FRAME_NUM_BITS-1:0] base, logic [COUNT_W-1:0] size,
                            logic info);
        stop_req();
        wait_drained();
        write_reg(CFG_POOL_BASE, CFG_DATA_W'(base));
        write_reg(CFG_POOL_SIZE, CFG_DATA_W'(size));
        write_reg(CFG_INFO, CFG_DATA_W'(info));
        cfg_valid <= 1'b0;
        settings++;
    endtask

    // mostly well-formed requests against the current pool, some noise
    task automatic run_random(int n, int max_count);
        int                        sel;
        int                        sz;
        int                        idx;
        logic [FUNC_W-1:0]         func;
        logic [FRAME_NUM_BITS-1:0] frame;
        logic [COUNT_W-1:0]        count;
        for (int k = 0; k < n; k++)
        begin
            sz    = sb.live_size();
            sel   = $urandom_range(0, 99);
            idx   = $urandom_range(0, sz - 1);
            frame = sb.base + idx[FRAME_NUM_BITS-1:0];
            count = COUNT_W'($urandom_range(1, max_count));
            if (sel < 40)
                func = FN_ALLOC;
            else if (sel < 72)
            begin
                // usually release a live run, sometimes whatever is there
                func = FN_RELEASE;
                if ($urandom_range(0, 99) < 80)
                begin
                    idx = sb.find_head(idx);
                    if (idx >= 0)
                        frame = sb.base + idx[FRAME_NUM_BITS-1:0];
                end
            end
            else if (sel < 88)
            begin
                func  = FN_RESERVE;
                count = COUNT_W'($urandom_range(0, max_count));
            end
            else
            begin
                func  = FUNC_W'($urandom_range(0, 3));
                frame = FRAME_NUM_BITS'($urandom);
                count = COUNT_W'($urandom);
            end
            send_req(func, frame, count);
        end
    endtask

    initial
    begin
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset pool: base 0, full size, info frame held at frame 0
        send_req(FN_ALLOC,   20'd0,       15'd0);
        send_req(FN_ALLOC,   20'd0,       15'd16384);
        send_req(FN_ALLOC,   20'd0,       15'h7fff);
        send_req(FN_RELEASE, 20'd0,       15'd0);
        send_req(FN_ALLOC,   20'd0,       15'd16384);
        send_req(FN_ALLOC,   20'd0,       15'd1);
        send_req(FN_RELEASE, 20'd0,       15'h7fff);
        send_req(FN_RELEASE, 20'd5,       15'd1);
        send_req(FN_RELEASE, 20'hfffff,   15'd1);
        send_req(FN_RESERVE, 20'hfffff,   15'd1);
        send_req(FN_ALLOC,   20'hfffff,   15'd3);
        send_req(FN_ALLOC,   20'd0,       15'd2);
        // release in the middle of a run
        send_req(FN_RELEASE, 20'd1,       15'd0);
        // reserve clipped at the pool end
        send_req(FN_RESERVE, 20'd16380,   15'd100);
        // zero reserve count marks a single head
        send_req(FN_RESERVE, 20'd10,      15'd0);
        // reserve over live runs: the used frame after the range joins the new run
        send_req(FN_RESERVE, 20'd2,       15'd2);
        send_req(FN_RELEASE, 20'd2,       15'd0);
        send_req(FN_RELEASE, 20'd0,       15'd0);
        send_req(FN_UNUSED,  20'd0,       15'd1);
        send_req(FN_RELEASE, 20'd16383,   15'd0);
        send_req(FN_RELEASE, 20'd16380,   15'd0);
        send_req(FN_ALLOC,   20'd0,       15'd5);

        // small pool wrapping past the top of the frame space
        set_pool(20'hffff0, 15'd40, 1'b1);
        run_random(35, 8);

        // size zero acts as a single frame
        set_pool(20'd0, 15'd0, 1'b0);
        run_random(10, 2);

        // oversized size register saturates to the full bitmap
        set_pool(20'h12345, 15'h7fff, 1'b0);
        run_random(15, 64);

        // back-to-back traffic, no gaps on either side
        set_pool(FRAME_NUM_BITS'($urandom), 15'd100, 1'b1);
        steady_flow = 1'b1;
        run_random(40, 20);
        stop_req();
        wait_drained();
        steady_flow = 1'b0;

        // one-frame pool already taken by the info frame, base at the top
        set_pool(20'hfffff, 15'd1, 1'b1);
        run_random(6, 1);

        set_pool(FRAME_NUM_BITS'($urandom), 15'd64, 1'b0);
        run_random(12, 12);

        stop_req();
        wait_drained();

        $display("summary: %0d requests over %0d pool settings, %0d results checked",
                 sb.requests, settings, sb.checked);
        $display("summary: alloc, release, reserve and the unused code, pools of 1 to %0d frames",
                 MAX_FRAMES);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // hang guard, far above the slowest legal run
    initial
    begin
        #30000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
